// File: rtl/bsb_pkg.sv
package bsb_pkg;

  localparam int ChW     = 8;
  localparam int NumCh   = 4;
  localparam int PixW    = NumCh * ChW;
  localparam int CfgIdxW = 2;
  localparam int SumW    = ChW + 2;

  typedef logic [ChW-1:0]     chan_t;
  typedef logic [PixW-1:0]    pixel_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_FRAC_X = 2'd0;
  localparam cfg_idx_t REG_FRAC_Y = 2'd1;

  localparam chan_t CH_MAX = 8'd255;

  // Bilinear weights for the four texels.
  typedef struct packed {
    chan_t tl;
    chan_t tr;
    chan_t bl;
    chan_t br;
  } weights_t;

  // With both fractions at zero all the weight sits on the bottom-right texel.
  localparam weights_t WEIGHTS_RESET = '{tl: 8'd0, tr: 8'd0, bl: 8'd0, br: 8'd254};

  function automatic chan_t scale8(chan_t c, chan_t s);
    logic [2*ChW-1:0] p;
    p = (2*ChW)'(c) * (2*ChW)'(s);
    return p[2*ChW-1:ChW];
  endfunction

  function automatic chan_t clamp8(logic [SumW-1:0] v);
    return (v > SumW'(CH_MAX)) ? CH_MAX : v[ChW-1:0];
  endfunction

endpackage

// File: rtl/bsb_weight_regs.sv
module bsb_weight_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  bsb_pkg::cfg_idx_t  cfg_index,
  input  bsb_pkg::chan_t     cfg_data,
  output bsb_pkg::weights_t  weights
);
  import bsb_pkg::*;

  chan_t    frac_x_r, frac_x_nxt;
  chan_t    frac_y_r, frac_y_nxt;
  weights_t weights_r, weights_nxt;
  chan_t    inv_x, inv_y;

  always_comb begin
    frac_x_nxt = frac_x_r;
    frac_y_nxt = frac_y_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAC_X: frac_x_nxt = cfg_data;
        REG_FRAC_Y: frac_y_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // The weights are recomputed whenever a fraction is written, so the
  // datapath never sees a multiplier chain on the fractions.
  always_comb begin
    inv_x = CH_MAX - frac_x_nxt;
    inv_y = CH_MAX - frac_y_nxt;
    weights_nxt.tl = scale8(frac_x_nxt, frac_y_nxt);
    weights_nxt.tr = scale8(inv_x, frac_y_nxt);
    weights_nxt.bl = scale8(frac_x_nxt, inv_y);
    weights_nxt.br = scale8(inv_x, inv_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_x_r  <= '0;
      frac_y_r  <= '0;
      weights_r <= WEIGHTS_RESET;
    end else if (cfg_valid) begin
      frac_x_r  <= frac_x_nxt;
      frac_y_r  <= frac_y_nxt;
      weights_r <= weights_nxt;
    end
  end

  assign weights = weights_r;

endmodule

// File: rtl/bsb_filter.sv
module bsb_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  bsb_pkg::pixel_t   texel_tl,
  input  bsb_pkg::pixel_t   texel_tr,
  input  bsb_pkg::pixel_t   texel_bl,
  input  bsb_pkg::pixel_t   texel_br,
  input  bsb_pkg::pixel_t   dest_in,
  input  bsb_pkg::weights_t weights,
  output logic              sum_valid,
  output bsb_pkg::pixel_t   sum_pixel,
  output bsb_pkg::pixel_t   sum_dest
);
  import bsb_pkg::*;

  // Stage one: each texel channel scaled by its weight.
  chan_t  prod_tl_r [NumCh];
  chan_t  prod_tr_r [NumCh];
  chan_t  prod_bl_r [NumCh];
  chan_t  prod_br_r [NumCh];
  chan_t  prod_tl_nxt [NumCh];
  chan_t  prod_tr_nxt [NumCh];
  chan_t  prod_bl_nxt [NumCh];
  chan_t  prod_br_nxt [NumCh];
  pixel_t s1_dest_r;
  logic   s1_valid_r;

  // Stage two: per-channel sum of the scaled texels.
  pixel_t sum_r, sum_nxt;
  pixel_t s2_dest_r;
  logic   s2_valid_r;

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      prod_tl_nxt[k] = scale8(texel_tl[k*ChW +: ChW], weights.tl);
      prod_tr_nxt[k] = scale8(texel_tr[k*ChW +: ChW], weights.tr);
      prod_bl_nxt[k] = scale8(texel_bl[k*ChW +: ChW], weights.bl);
      prod_br_nxt[k] = scale8(texel_br[k*ChW +: ChW], weights.br);
    end
  end

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      sum_nxt[k*ChW +: ChW] = clamp8(SumW'(prod_tl_r[k]) + SumW'(prod_tr_r[k])
                                   + SumW'(prod_bl_r[k]) + SumW'(prod_br_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_tl_r <= prod_tl_nxt;
    prod_tr_r <= prod_tr_nxt;
    prod_bl_r <= prod_bl_nxt;
    prod_br_r <= prod_br_nxt;
    s1_dest_r <= dest_in;
    sum_r     <= sum_nxt;
    s2_dest_r <= s1_dest_r;
  end

  assign sum_valid = s2_valid_r;
  assign sum_pixel = sum_r;
  assign sum_dest  = s2_dest_r;

endmodule

// File: rtl/bsb_blend.sv
module bsb_blend (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            sum_valid,
  input  bsb_pkg::pixel_t sum_pixel,
  input  bsb_pkg::pixel_t sum_dest,
  output logic            out_valid,
  output bsb_pkg::pixel_t out_pixel
);
  import bsb_pkg::*;

  chan_t  alpha, inv_alpha;
  chan_t  src_r [NumCh];
  chan_t  dst_r [NumCh];
  chan_t  src_nxt [NumCh];
  chan_t  dst_nxt [NumCh];
  logic   s3_valid_r;
  pixel_t out_r, out_nxt;
  logic   out_valid_r;

  // The filtered alpha weights the source; its complement weights the
  // destination.
  always_comb begin
    alpha     = sum_pixel[PixW-1 -: ChW];
    inv_alpha = CH_MAX - alpha;
    for (int k = 0; k < NumCh; k++) begin
      src_nxt[k] = scale8(sum_pixel[k*ChW +: ChW], alpha);
      dst_nxt[k] = scale8(sum_dest[k*ChW +: ChW], inv_alpha);
    end
  end

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      out_nxt[k*ChW +: ChW] = clamp8(SumW'(src_r[k]) + SumW'(dst_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s3_valid_r  <= sum_valid;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    dst_r <= dst_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_r;

endmodule

// File: rtl/bilinear_alpha_sprite_blend_unit.sv
// Channel   Ports                                    Handshake
// request   start, busy, in_texel_*, in_dest_pixel   taken when start && !busy
// result    out_valid, out_blended_pixel             one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data written when valid && ready
//
// A request is accepted every cycle while busy is low and passes through four registered stages.
// The four stages are: weighted texel products, per-channel sum, alpha and
// destination products, final add and clamp.
// Reset is synchronous and active low; busy is a registered copy of the inverted
// reset, so it stays high until the first clock edge that samples reset released.
// The result side cannot stall, so the pipeline always advances.
module bilinear_alpha_sprite_blend_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bsb_pkg::pixel_t   in_texel_top_left,
  input  bsb_pkg::pixel_t   in_texel_top_right,
  input  bsb_pkg::pixel_t   in_texel_bottom_left,
  input  bsb_pkg::pixel_t   in_texel_bottom_right,
  input  bsb_pkg::pixel_t   in_dest_pixel,
  output logic              out_valid,
  output bsb_pkg::pixel_t   out_blended_pixel,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  bsb_pkg::cfg_idx_t cfg_index,
  input  bsb_pkg::chan_t    cfg_data
);
  import bsb_pkg::*;

  logic     busy_r;
  logic     req_accept;
  weights_t weights;
  logic     sum_valid;
  pixel_t   sum_pixel;
  pixel_t   sum_dest;

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy       = busy_r;
  assign cfg_ready  = 1'b1;
  assign req_accept = start && !busy_r;

  bsb_weight_regs u_weights (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .weights   (weights)
  );

  bsb_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req_accept),
    .texel_tl  (in_texel_top_left),
    .texel_tr  (in_texel_top_right),
    .texel_bl  (in_texel_bottom_left),
    .texel_br  (in_texel_bottom_right),
    .dest_in   (in_dest_pixel),
    .weights   (weights),
    .sum_valid (sum_valid),
    .sum_pixel (sum_pixel),
    .sum_dest  (sum_dest)
  );

  bsb_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_pixel (sum_pixel),
    .sum_dest  (sum_dest),
    .out_valid (out_valid),
    .out_pixel (out_blended_pixel)
  );

endmodule

// File: rtl/bsb_checker.sv
module bsb_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input bsb_pkg::pixel_t out_blended_pixel
);
  import bsb_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // Every accepted request yields exactly one result once it has passed the filter and blend stage registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted request produced no result after four cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result strobe without a matching request");

  // Once reset has been sampled released, the unit never refuses a request.
  a_not_busy: assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> !busy)
    else $error("busy raised outside reset");

  // The weights total at most 254, so no blended channel can saturate.
  a_no_saturation: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_blended_pixel[31:24] != CH_MAX
                   && out_blended_pixel[23:16] != CH_MAX
                   && out_blended_pixel[15:8] != CH_MAX
                   && out_blended_pixel[7:0] != CH_MAX))
    else $error("blended channel reached full scale");

endmodule

bind bilinear_alpha_sprite_blend_unit bsb_checker u_bsb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_blended_pixel (out_blended_pixel)
);
